FILE: rtl/csh_pkg.sv
// Package for the clipped sample histogram: sizes, operation codes,
// register indexes and the read sequencer state type.
// Used by clipped_sample_histogram_top; depends on nothing.
package csh_pkg;

    localparam int BINS        = 256;
    localparam int BIN_W       = $clog2(BINS);
    localparam int COUNT_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int HEIGHT_W    = 17;
    localparam int INDEX_W     = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int FRAC_STEPS  = 16;
    localparam int STEP_W      = $clog2(FRAC_STEPS + 1);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CLIP_LOW = 8'd0,
        REG_SCALE    = 8'd1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_MEM,
        ST_RD_DATA,
        ST_DIV,
        ST_DONE
    } rd_state_t;

endpackage

FILE: rtl/clipped_sample_histogram_top.sv
// Clipped sample histogram: 256 saturating bin counters in one synchronous
// memory, the running peak and the read sequencer with its height divider.
// Depends on csh_pkg.
//
// Add requests stream at one per cycle while the read sequencer is idle,
// through a four-stage pipeline (difference, multiply, round and memory
// read, increment and write back); a bin written in one cycle is forwarded
// to an add that read it in the same cycle. A clear request waits for the
// add pipeline to drain and then clears all bins at once, since each bin
// has a valid bit that clears at once. A read request also waits for the
// drain, then steps through the memory access, the bit-serial count/peak
// division, which is skipped when the peak is zero, and the load of the
// result register once the output is free. Configuration writes are always ready.
module clipped_sample_histogram_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [csh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [csh_pkg::FIELD_W-1:0]   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic signed [csh_pkg::FIELD_W-1:0] s_sample,
    input  logic [csh_pkg::INDEX_W-1:0]   s_bin_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [csh_pkg::FIELD_W-1:0]   m_bin_count,
    output logic [csh_pkg::FIELD_W-1:0]   m_peak_count,
    output logic [csh_pkg::HEIGHT_W-1:0]  m_normalized_height
);
    import csh_pkg::*;

    logic signed [FIELD_W-1:0] clip_low_reg;
    logic [FIELD_W-1:0]        scale_reg;

    logic [COUNT_WIDTH-1:0] mem [BINS];
    logic [COUNT_WIDTH-1:0] mem_rdata_reg;
    logic [BINS-1:0]        bin_valid_reg;
    logic                   vbit_reg;
    logic [BIN_W-1:0]       rd_addr;

    logic                   st1_valid_reg;
    logic                   st1_neg_reg;
    logic [FIELD_W-1:0]     st1_mag_reg;
    logic                   st2_valid_reg;
    logic                   st2_neg_reg;
    logic [2*FIELD_W-1:0]   st2_prod_reg;
    logic                   st3_valid_reg;
    logic [BIN_W-1:0]       st3_bin_reg;

    logic                   fwd_valid_reg;
    logic [BIN_W-1:0]       fwd_bin_reg;
    logic [COUNT_WIDTH-1:0] fwd_count_reg;

    logic [COUNT_WIDTH-1:0] peak_reg;

    rd_state_t              state_reg, state_next;
    logic [INDEX_W-1:0]     rd_idx_reg;
    logic [COUNT_WIDTH-1:0] rd_count_reg;
    logic [COUNT_WIDTH:0]   rem_reg;
    logic [HEIGHT_W-1:0]    quot_reg;
    logic [STEP_W-1:0]      step_reg;

    logic                   m_valid_reg;
    logic [FIELD_W-1:0]     m_bin_count_reg;
    logic [FIELD_W-1:0]     m_peak_count_reg;
    logic [HEIGHT_W-1:0]    m_height_reg;

    logic                   pipe_empty;
    logic                   accept;
    logic                   is_add;
    logic                   is_clear;
    logic                   is_read;
    logic signed [FIELD_W:0] diff;
    logic [2*FIELD_W:0]     rounded;
    logic [FIELD_W:0]       bin_wide;
    logic [BIN_W-1:0]       st2_bin;
    logic [COUNT_WIDTH-1:0] old_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic [COUNT_WIDTH-1:0] rd_count;
    logic [COUNT_WIDTH:0]   rem_sub;
    logic                   rem_ge;
    logic                   out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_low_reg <= '0;
            scale_reg    <= 32'h00FF_0000;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CLIP_LOW: clip_low_reg <= cfg_data;
                REG_SCALE:    scale_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clear and read requests need the add pipeline drained.
    assign pipe_empty = !st1_valid_reg && !st2_valid_reg && !st3_valid_reg;
    assign s_ready    = (state_reg == ST_IDLE) &&
                        (!(s_operation inside {OP_CLEAR, OP_READ}) || pipe_empty);
    assign accept     = s_valid && s_ready;
    assign is_add     = accept && (s_operation == OP_ADD);
    assign is_clear   = accept && (s_operation == OP_CLEAR);
    assign is_read    = accept && (s_operation == OP_READ);

    assign diff = {s_sample[FIELD_W-1], s_sample} -
                  {clip_low_reg[FIELD_W-1], clip_low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= is_add;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        st1_neg_reg  <= diff[FIELD_W];
        st1_mag_reg  <= diff[FIELD_W-1:0];
        st2_neg_reg  <= st1_neg_reg;
        st2_prod_reg <= st1_mag_reg * scale_reg;
        st3_bin_reg  <= st2_bin;
    end

    // Round to nearest by adding one half in Q32, then clamp to bins 0 to 255.
    assign rounded  = {1'b0, st2_prod_reg} + (65'd1 << (2 * FIELD_W - FIELD_W - 1));
    assign bin_wide = rounded[2*FIELD_W:FIELD_W];

    always_comb begin
        if (st2_neg_reg) begin
            st2_bin = '0;
        end else if (bin_wide > (FIELD_W + 1)'(BINS - 1)) begin
            st2_bin = BIN_W'(BINS - 1);
        end else begin
            st2_bin = bin_wide[BIN_W-1:0];
        end
    end

    assign rd_addr = st2_valid_reg ? st2_bin : rd_idx_reg[BIN_W-1:0];

    always_ff @(posedge aclk) begin
        mem_rdata_reg <= mem[rd_addr];
        if (st3_valid_reg) begin
            mem[st3_bin_reg] <= new_count;
        end
    end

    always_comb begin
        if (fwd_valid_reg && (fwd_bin_reg == st3_bin_reg)) begin
            old_count = fwd_count_reg;
        end else if (vbit_reg) begin
            old_count = mem_rdata_reg;
        end else begin
            old_count = '0;
        end
        new_count = (old_count == {COUNT_WIDTH{1'b1}}) ? old_count : old_count + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_valid_reg <= '0;
            vbit_reg      <= 1'b0;
            fwd_valid_reg <= 1'b0;
            peak_reg      <= '0;
        end else begin
            vbit_reg      <= bin_valid_reg[rd_addr];
            fwd_valid_reg <= st3_valid_reg;
            if (is_clear) begin
                bin_valid_reg <= '0;
                peak_reg      <= '0;
            end else if (st3_valid_reg) begin
                bin_valid_reg[st3_bin_reg] <= 1'b1;
                if (new_count > peak_reg) begin
                    peak_reg <= new_count;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        fwd_bin_reg   <= st3_bin_reg;
        fwd_count_reg <= new_count;
    end

    // Read sequencer with a restoring divider, one quotient bit per cycle.
    assign rd_count = (vbit_reg && (32'(rd_idx_reg) < 32'(BINS))) ? mem_rdata_reg : '0;
    assign rem_ge   = rem_reg >= {1'b0, peak_reg};
    assign rem_sub  = rem_reg - {1'b0, peak_reg};
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (is_read) state_next = ST_RD_MEM;
            ST_RD_MEM:  state_next = ST_RD_DATA;
            ST_RD_DATA: state_next = (peak_reg == '0) ? ST_DONE : ST_DIV;
            ST_DIV:     if (step_reg == '0) state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (is_read) begin
            rd_idx_reg <= s_bin_index;
        end
        case (state_reg)
            ST_RD_DATA: begin
                rd_count_reg <= rd_count;
                rem_reg      <= {1'b0, rd_count};
                quot_reg     <= '0;
                step_reg     <= STEP_W'(FRAC_STEPS);
            end
            ST_DIV: begin
                rem_reg  <= rem_ge ? {rem_sub[COUNT_WIDTH-1:0], 1'b0}
                                   : {rem_reg[COUNT_WIDTH-1:0], 1'b0};
                quot_reg <= {quot_reg[HEIGHT_W-2:0], rem_ge};
                step_reg <= step_reg - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_bin_count_reg  <= FIELD_W'(rd_count_reg);
            m_peak_count_reg <= FIELD_W'(peak_reg);
            m_height_reg     <= quot_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_bin_count         = m_bin_count_reg;
    assign m_peak_count        = m_peak_count_reg;
    assign m_normalized_height = m_height_reg;

endmodule
